FILE: rtl/core/hmsc_pkg.sv
// Shared types, character constants and the time-advance function for the
// HH:MM:SS clock with serial commands. No dependencies.
package hmsc_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam logic [15:0] TPS_RESET       = 16'd200;

    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_1   = 8'h31;
    localparam logic [7:0] CH_2   = 8'h32;
    localparam logic [7:0] CH_3   = 8'h33;
    localparam logic [7:0] CH_4   = 8'h34;
    localparam logic [7:0] CH_5   = 8'h35;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_T   = 8'h74;
    localparam logic [7:0] CH_C   = 8'h63;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_COL = 8'h3A;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic [2:0] SET_LAST  = 3'd5;
    localparam logic [3:0] REPLY_LAST = 4'd9;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_SKIP,
        OP_ARM,
        OP_STORE,
        OP_GET,
        OP_TOGGLE,
        OP_ECHO
    } hmsc_op_t;

    typedef struct packed {
        hmsc_op_t    op;
        logic [2:0]  idx;
        logic [7:0]  data;
    } hmsc_cmd_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  rx_byte;
    } hmsc_in_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        last;
        logic [7:0]  hour_tens;
        logic [7:0]  hour_ones;
        logic [7:0]  minute_tens;
        logic [7:0]  minute_ones;
        logic [7:0]  second_tens;
        logic [7:0]  second_ones;
        logic        colon_shown;
        logic        led_on;
    } hmsc_out_t;

    // Entry 0 is the hours tens digit, entry 5 the seconds ones digit.
    typedef logic [0:5][7:0] hmsc_digits_t;

    function automatic hmsc_digits_t hmsc_advance(hmsc_digits_t d);
        hmsc_digits_t r;
        logic [7:0]   h1;
        logic [7:0]   h0;
        r  = d;
        h1 = d[1] + 8'd1;
        h0 = d[0] + 8'd1;
        r[5] = d[5] + 8'd1;
        if (d[5] == CH_9) begin
            r[5] = CH_0;
            r[4] = d[4] + 8'd1;
            if (d[4] == CH_5) begin
                r[4] = CH_0;
                r[3] = d[3] + 8'd1;
                if (d[3] == CH_9) begin
                    r[3] = CH_0;
                    r[2] = d[2] + 8'd1;
                    if (d[2] == CH_5) begin
                        r[2] = CH_0;
                        r[1] = h1;
                        if ((d[1] == CH_9 && d[0] != CH_2) ||
                            (h1 == CH_4 && d[0] == CH_2)) begin
                            r[1] = CH_0;
                            r[0] = (h0 == CH_3) ? CH_0 : h0;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/hms_clock_with_serial_commands_top.sv
// Top level of the HH:MM:SS clock with serial set/get commands.
// Depends on hmsc_pkg, hmsc_front, hmsc_queue and hmsc_back.
//
// The input channel (s_valid, s_ready, s_data), while ready, takes one
// item per cycle: a timer tick (kind 0) or a received serial byte (kind 1).
// The result channel (m_valid, m_ready, m_data) returns one result per item,
// and ten results for the time query command, the final one marked last.
// Each result also carries the six time digits, the separator state and
// the LED level as they stand after the item.
// An item's first result passes through the command queue and the result
// register before it is presented on the result channel. Single-result items
// sustain one per cycle while the receiver is ready; a time query holds the
// back end until all ten of its reply bytes have been issued.
// The front end and back end are parted by a four-entry command queue, so
// input keeps flowing while the receiver stalls until the queue fills, at
// which point s_ready drops. The result register holds its item under stall.
// cfg_wr_en with cfg_wr_data sets ticks per second; it takes effect at the
// next reload of the prescaler. Reset sets the time to 00:00:00 with colons
// shown, the LED off, and ticks per second and the prescaler to 200.
module hms_clock_with_serial_commands_top import hmsc_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  hmsc_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output hmsc_out_t   m_data
);

    logic      q_push, q_full, q_pop, q_empty;
    hmsc_cmd_t push_cmd, head_cmd;

    hmsc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    hmsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    hmsc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (q_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    a_non_last_transmits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> m_data.tx_valid)
        else $error("A non-final result carries no transmit byte.");

    a_idle_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.tx_valid) |-> (m_data.tx_byte == 8'd0))
        else $error("A result without a transmit byte has a nonzero byte.");

    a_reply_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last) |=> m_valid)
        else $error("The time reply stopped before its final byte.");

endmodule

FILE: rtl/core/hmsc_front.sv
// Front end: accepts input items, tracks the digit-load mode and classifies
// each item into a command for the queue. Depends on hmsc_pkg.
module hmsc_front import hmsc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  hmsc_in_t  s_data,
    input  logic      q_full,
    output logic      q_push,
    output hmsc_cmd_t q_cmd
);

    logic       set_mode_reg, set_mode_next;
    logic [2:0] set_index_reg, set_index_next;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_cmd.idx      = set_index_reg;
        q_cmd.data     = s_data.rx_byte;
        set_mode_next  = set_mode_reg;
        set_index_next = set_index_reg;
        priority if (!s_data.kind) begin
            q_cmd.op = set_mode_reg ? OP_SKIP : OP_TICK;
        end else if (set_mode_reg) begin
            q_cmd.op       = OP_STORE;
            set_index_next = set_index_reg + 3'd1;
            if (set_index_reg == SET_LAST) begin
                set_mode_next  = 1'b0;
                set_index_next = 3'd0;
            end
        end else if (s_data.rx_byte == CH_1) begin
            q_cmd.op       = OP_ARM;
            set_mode_next  = 1'b1;
            set_index_next = 3'd0;
        end else if (s_data.rx_byte == CH_2) begin
            q_cmd.op = OP_GET;
        end else if (s_data.rx_byte == CH_T) begin
            q_cmd.op = OP_TOGGLE;
        end else begin
            q_cmd.op = OP_ECHO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_mode_reg  <= 1'b0;
            set_index_reg <= 3'd0;
        end else if (q_push) begin
            set_mode_reg  <= set_mode_next;
            set_index_reg <= set_index_next;
        end
    end

endmodule

FILE: rtl/core/hmsc_queue.sv
// Small first-in first-out queue of classified commands between the front
// end and the back end. Depends on hmsc_pkg.
module hmsc_queue import hmsc_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  hmsc_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output hmsc_cmd_t head_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    hmsc_cmd_t         entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/hmsc_back.sv
// Back end: holds the time, separator, LED and prescaler, carries out queued
// commands and drives the registered result channel. Depends on hmsc_pkg.
module hmsc_back import hmsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        q_empty,
    input  hmsc_cmd_t   q_cmd,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output hmsc_out_t   m_data
);

    hmsc_digits_t digits_reg, digits_next;
    logic         sep_reg, sep_next;
    logic         led_reg, led_next;
    logic [15:0]  count_reg, count_next, count_dec;
    logic [15:0]  tps_reg;
    logic [3:0]   beat_reg;
    logic         m_valid_reg;
    hmsc_out_t    m_data_reg, result;
    logic         fire;
    logic [7:0]   sep_char, reply_byte;

    assign fire    = !q_empty && (!m_valid_reg || m_ready);
    assign q_pop   = fire && (q_cmd.op != OP_GET || beat_reg == REPLY_LAST);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign count_dec = count_reg - 16'd1;
    assign sep_char  = sep_reg ? CH_COL : CH_SP;

    always_comb begin
        unique case (beat_reg)
            4'd0:    reply_byte = digits_reg[0];
            4'd1:    reply_byte = digits_reg[1];
            4'd2:    reply_byte = sep_char;
            4'd3:    reply_byte = digits_reg[2];
            4'd4:    reply_byte = digits_reg[3];
            4'd5:    reply_byte = sep_char;
            4'd6:    reply_byte = digits_reg[4];
            4'd7:    reply_byte = digits_reg[5];
            4'd8:    reply_byte = CH_VT;
            default: reply_byte = CH_C;
        endcase
    end

    always_comb begin
        digits_next     = digits_reg;
        sep_next        = sep_reg;
        led_next        = led_reg;
        count_next      = count_reg;
        result.tx_valid = 1'b0;
        result.tx_byte  = 8'd0;
        result.last     = 1'b1;
        unique case (q_cmd.op)
            OP_TICK: begin
                count_next = count_dec;
                if (count_dec == 16'd0) begin
                    count_next  = tps_reg;
                    digits_next = hmsc_advance(digits_reg);
                    sep_next    = !sep_reg;
                    led_next    = !led_reg;
                end
            end
            OP_STORE: begin
                digits_next[q_cmd.idx] = q_cmd.data;
            end
            OP_GET: begin
                result.tx_valid = 1'b1;
                result.tx_byte  = reply_byte;
                result.last     = (beat_reg == REPLY_LAST);
            end
            OP_TOGGLE: begin
                led_next = !led_reg;
            end
            OP_ECHO: begin
                result.tx_valid = 1'b1;
                result.tx_byte  = q_cmd.data;
            end
            default: begin
            end
        endcase
        result.hour_tens   = digits_next[0];
        result.hour_ones   = digits_next[1];
        result.minute_tens = digits_next[2];
        result.minute_ones = digits_next[3];
        result.second_tens = digits_next[4];
        result.second_ones = digits_next[5];
        result.colon_shown = sep_next;
        result.led_on      = led_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_reg  <= {6{CH_0}};
            sep_reg     <= 1'b1;
            led_reg     <= 1'b0;
            count_reg   <= TPS_RESET;
            tps_reg     <= TPS_RESET;
            beat_reg    <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                tps_reg <= cfg_wr_data;
            end
            if (fire) begin
                digits_reg  <= digits_next;
                sep_reg     <= sep_next;
                led_reg     <= led_next;
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
                if (q_cmd.op == OP_GET && beat_reg != REPLY_LAST) begin
                    beat_reg <= beat_reg + 4'd1;
                end else begin
                    beat_reg <= 4'd0;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= result;
        end
    end

endmodule
